// ----- rtl/bfi_pkg.sv -----
// bfi_pkg: shared types and constants for the brainfuck interpreter core
// holds command codes, run states, opcode characters, sequencer states and unit structs
// no dependencies
package bfi_pkg;

    localparam int BFI_PROG_DEPTH = 4096;
    localparam int BFI_TAPE_DEPTH = 32768;

    localparam int PC_W    = 13;
    localparam int DEPTH_W = 14;
    localparam int ALU_W   = 16;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    localparam logic [1:0] RUN_ACTIVE = 2'd0;
    localparam logic [1:0] RUN_END    = 2'd1;
    localparam logic [1:0] RUN_ERROR  = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_ADVANCE,
        S_CHECK,
        S_FSTEP,
        S_FCHK,
        S_BCHK,
        S_BSTEP,
        S_BRD,
        S_EVAL,
        S_FINISH
    } bfi_state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;
    } alu_rsp_t;

endpackage

// ----- rtl/brainfuck_interpreter_core.sv -----
// brainfuck_interpreter_core: top level, sequencer, program memory and tape
// depends on bfi_pkg, bfi_ram, bfi_alu
//
// channel   signals                                      direction
// command   cmd_valid, cmd_stall, command, address,      in
//           program_byte, input_byte
// result    res_valid, res_stall, run_state, out_valid,  out
//           out_byte, input_used, next_pc
// config    cfg_wr_en, cfg_wr_data                       in
//
// load/unused: idle, finish; plain instructions: fetch, exec, advance, check, finish
// bracket scan, per byte: forward fstep, fchk, eval; backward bchk, bstep, brd, eval
// reset and restart sweep the tape one cell a cycle, all cells, with no command transfer
// a new command transfer is taken while an earlier result still waits on res_stall
module brainfuck_interpreter_core
    import bfi_pkg::*;
#(
    parameter int PROG_DEPTH = BFI_PROG_DEPTH,
    parameter int TAPE_DEPTH = BFI_TAPE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [PC_W-1:0] cfg_wr_data,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  logic [1:0]      command,
    input  logic [11:0]     address,
    input  logic [7:0]      program_byte,
    input  logic [7:0]      input_byte,
    output logic            res_valid,
    input  logic            res_stall,
    output logic [1:0]      run_state,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            input_used,
    output logic [PC_W-1:0] next_pc
);

    localparam int PA = $clog2(PROG_DEPTH);
    localparam int TA = $clog2(TAPE_DEPTH);
    localparam logic [31:0] PD32 = 32'(PROG_DEPTH);
    localparam logic [TA-1:0] TAPE_LAST = TA'(TAPE_DEPTH - 1);

    bfi_state_t state_reg, state_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [TA-1:0]      ptr_reg, ptr_next;
    logic [1:0]         halt_reg, halt_next;
    logic [PC_W-1:0]    plen_reg;
    logic [TA-1:0]      clr_reg, clr_next;
    logic               item_reg, item_next;
    logic               res_full_reg, res_full_next;

    logic [PC_W-1:0]    scan_reg, scan_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               dir_reg, dir_next;
    logic [7:0]         op_reg, op_next;
    logic [7:0]         cell_reg, cell_next;
    logic [7:0]         ibyte_reg, ibyte_next;
    logic               dot_reg, dot_next;
    logic [7:0]         dbyte_reg, dbyte_next;
    logic               used_reg, used_next;
    logic [1:0]         rs_reg;
    logic               ov_reg;
    logic [7:0]         ob_reg;
    logic               iu_reg;
    logic [PC_W-1:0]    npc_reg;

    logic [PC_W-1:0]    limit;
    logic               accept;
    logic               take;
    logic               load;
    logic               addr_ok;
    logic [31:0]        addr_ext;
    logic [31:0]        raddr_ext;
    logic [PC_W-1:0]    prog_raddr_pc;

    logic               prog_we;
    logic [PA-1:0]      prog_waddr;
    logic [PA-1:0]      prog_raddr;
    logic [7:0]         prog_rdata;

    logic               tape_we;
    logic [TA-1:0]      tape_waddr;
    logic [7:0]         tape_wdata;
    logic [7:0]         tape_rdata;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic [7:0]         open_ch;
    logic [7:0]         close_ch;

    assign limit     = (32'(plen_reg) < PD32) ? plen_reg : PC_W'(PROG_DEPTH);
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign res_valid = res_full_reg;
    assign take      = res_full_reg && !res_stall;
    assign load      = (state_reg == S_FINISH) && (!res_full_reg || !res_stall);

    assign addr_ext   = 32'(address);
    assign addr_ok    = addr_ext < PD32;
    assign prog_we    = accept && (command == CMD_LOAD) && addr_ok;
    assign prog_waddr = addr_ext[PA-1:0];

    assign prog_raddr_pc = ((state_reg == S_FCHK) || (state_reg == S_BRD)) ? scan_reg : pc_reg;
    assign raddr_ext     = 32'(prog_raddr_pc);
    assign prog_raddr    = raddr_ext[PA-1:0];

    assign open_ch  = dir_reg ? CH_OPEN : CH_CLOSE;
    assign close_ch = dir_reg ? CH_CLOSE : CH_OPEN;

    assign run_state  = rs_reg;
    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign input_used = iu_reg;
    assign next_pc    = npc_reg;

    bfi_ram #(
        .WIDTH (8),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (program_byte),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfi_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (ptr_reg),
        .rdata (tape_rdata)
    );

    bfi_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        ptr_next      = ptr_reg;
        halt_next     = halt_reg;
        clr_next      = clr_reg;
        item_next     = item_reg;
        scan_next     = scan_reg;
        depth_next    = depth_reg;
        dir_next      = dir_reg;
        op_next       = op_reg;
        cell_next     = cell_reg;
        ibyte_next    = ibyte_reg;
        dot_next      = dot_reg;
        dbyte_next    = dbyte_reg;
        used_next     = used_reg;
        tape_we       = 1'b0;
        tape_waddr    = ptr_reg;
        tape_wdata    = 8'd0;
        alu_req.a     = ALU_W'(pc_reg);
        alu_req.b     = ALU_W'(limit);
        alu_req.sub   = 1'b1;
        res_full_next = res_full_reg;

        if (take)
        begin
            res_full_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                tape_wdata = 8'd0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == TAPE_LAST)
                begin
                    clr_next   = '0;
                    state_next = item_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                // pc against limit
                alu_req.a   = ALU_W'(pc_reg);
                alu_req.b   = ALU_W'(limit);
                alu_req.sub = 1'b1;
                if (accept)
                begin
                    item_next  = 1'b1;
                    dot_next   = 1'b0;
                    dbyte_next = 8'd0;
                    used_next  = 1'b0;
                    ibyte_next = input_byte;
                    case (command)
                        CMD_LOAD:
                        begin
                            state_next = S_FINISH;
                        end
                        CMD_EXEC:
                        begin
                            if (halt_reg != RUN_ACTIVE)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (alu_rsp.ge)
                            begin
                                halt_next  = RUN_END;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        CMD_RESTART:
                        begin
                            pc_next    = '0;
                            ptr_next   = '0;
                            halt_next  = RUN_ACTIVE;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                op_next    = prog_rdata;
                cell_next  = tape_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_ADVANCE;
                case (op_reg)
                    CH_GT:
                    begin
                        alu_req.a   = ALU_W'(ptr_reg);
                        alu_req.b   = ALU_W'(1);
                        alu_req.sub = 1'b0;
                        ptr_next    = (ptr_reg == TAPE_LAST) ? '0 : alu_rsp.sum[TA-1:0];
                    end
                    CH_LT:
                    begin
                        alu_req.a   = ALU_W'(ptr_reg);
                        alu_req.b   = ALU_W'(1);
                        alu_req.sub = 1'b1;
                        ptr_next    = (ptr_reg == '0) ? TAPE_LAST : alu_rsp.sum[TA-1:0];
                    end
                    CH_PLUS, CH_MINUS:
                    begin
                        alu_req.a   = ALU_W'(cell_reg);
                        alu_req.b   = ALU_W'(1);
                        alu_req.sub = (op_reg == CH_MINUS);
                        tape_we     = 1'b1;
                        tape_wdata  = alu_rsp.sum[7:0];
                    end
                    CH_DOT:
                    begin
                        dot_next   = 1'b1;
                        dbyte_next = cell_reg;
                    end
                    CH_COMMA:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = ibyte_reg;
                        used_next  = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        if (cell_reg == 8'd0)
                        begin
                            depth_next = DEPTH_W'(1);
                            scan_next  = pc_reg;
                            dir_next   = 1'b1;
                            state_next = S_FSTEP;
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (cell_reg != 8'd0)
                        begin
                            depth_next = DEPTH_W'(1);
                            scan_next  = pc_reg;
                            dir_next   = 1'b0;
                            state_next = S_BCHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_ADVANCE;
                    end
                endcase
            end
            S_ADVANCE:
            begin
                alu_req.a   = ALU_W'(pc_reg);
                alu_req.b   = ALU_W'(1);
                alu_req.sub = 1'b0;
                pc_next     = alu_rsp.sum[PC_W-1:0];
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                alu_req.a   = ALU_W'(pc_reg);
                alu_req.b   = ALU_W'(limit);
                alu_req.sub = 1'b1;
                if (alu_rsp.ge)
                begin
                    halt_next = RUN_END;
                end
                state_next = S_FINISH;
            end
            S_FSTEP:
            begin
                alu_req.a   = ALU_W'(scan_reg);
                alu_req.b   = ALU_W'(1);
                alu_req.sub = 1'b0;
                scan_next   = alu_rsp.sum[PC_W-1:0];
                state_next  = S_FCHK;
            end
            S_FCHK:
            begin
                alu_req.a   = ALU_W'(scan_reg);
                alu_req.b   = ALU_W'(limit);
                alu_req.sub = 1'b1;
                if (alu_rsp.ge)
                begin
                    halt_next  = RUN_ERROR;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_BCHK:
            begin
                // no borrow on scan - 1 means scan is nonzero
                alu_req.a   = ALU_W'(scan_reg);
                alu_req.b   = ALU_W'(1);
                alu_req.sub = 1'b1;
                if (alu_rsp.ge)
                begin
                    state_next = S_BSTEP;
                end
                else
                begin
                    halt_next  = RUN_ERROR;
                    state_next = S_FINISH;
                end
            end
            S_BSTEP:
            begin
                alu_req.a   = ALU_W'(scan_reg);
                alu_req.b   = ALU_W'(1);
                alu_req.sub = 1'b1;
                scan_next   = alu_rsp.sum[PC_W-1:0];
                state_next  = S_BRD;
            end
            S_BRD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                alu_req.a   = ALU_W'(depth_reg);
                alu_req.b   = ALU_W'(1);
                alu_req.sub = (prog_rdata == close_ch);
                state_next  = dir_reg ? S_FSTEP : S_BCHK;
                if (prog_rdata == open_ch)
                begin
                    depth_next = alu_rsp.sum[DEPTH_W-1:0];
                end
                else if (prog_rdata == close_ch)
                begin
                    depth_next = alu_rsp.sum[DEPTH_W-1:0];
                    if (alu_rsp.sum[DEPTH_W-1:0] == '0)
                    begin
                        pc_next    = scan_reg;
                        state_next = S_ADVANCE;
                    end
                end
            end
            S_FINISH:
            begin
                if (load)
                begin
                    res_full_next = 1'b1;
                    item_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pc_reg       <= '0;
            ptr_reg      <= '0;
            halt_reg     <= RUN_ACTIVE;
            plen_reg     <= '0;
            clr_reg      <= '0;
            item_reg     <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            ptr_reg      <= ptr_next;
            halt_reg     <= halt_next;
            clr_reg      <= clr_next;
            item_reg     <= item_next;
            res_full_reg <= res_full_next;
            if (cfg_wr_en)
            begin
                plen_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        depth_reg <= depth_next;
        dir_reg   <= dir_next;
        op_reg    <= op_next;
        cell_reg  <= cell_next;
        ibyte_reg <= ibyte_next;
        dot_reg   <= dot_next;
        dbyte_reg <= dbyte_next;
        used_reg  <= used_next;
        if (load)
        begin
            rs_reg  <= halt_reg;
            ov_reg  <= dot_reg;
            ob_reg  <= dbyte_reg;
            iu_reg  <= used_reg;
            npc_reg <= pc_reg;
        end
    end

endmodule

// ----- rtl/bfi_ram.sv -----
// bfi_ram: generic single write port, single read port memory with registered read
// no dependencies
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bfi_alu.sv -----
// bfi_alu: shared add/subtract unit with unsigned compare flag
// depends on bfi_pkg
module bfi_alu
    import bfi_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] full;

    assign full    = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                   + {{ALU_W{1'b0}}, req.sub};
    assign rsp.sum = full[ALU_W-1:0];
    assign rsp.ge  = full[ALU_W];

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// testbench for brainfuck_interpreter_core: directed programs, then random programs with idling
// each result transfer is checked against an in-bench model of the machine
// depends on bfi_pkg and the core rtl
module testbench
    import bfi_pkg::*;
();

    localparam int LIMIT_CYCLES = 50_000_000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int FILL_TOP     = 128;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]      run_state;
        logic            out_valid;
        logic [7:0]      out_byte;
        logic            input_used;
        logic [PC_W-1:0] next_pc;
    } bf_result_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [PC_W-1:0] cfg_wr_data;
    logic            cmd_valid;
    logic            cmd_stall;
    logic [1:0]      command;
    logic [11:0]     address;
    logic [7:0]      program_byte;
    logic [7:0]      input_byte;
    logic            res_valid;
    logic            res_stall;
    logic [1:0]      run_state;
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            input_used;
    logic [PC_W-1:0] next_pc;

    // machine state as the bench sees it
    logic [7:0]      bf_prog [BFI_PROG_DEPTH];
    logic [7:0]      bf_tape [BFI_TAPE_DEPTH];
    logic [PC_W-1:0] bf_pc;
    logic [14:0]     bf_cell;
    logic [1:0]      bf_halt;
    logic [PC_W-1:0] bf_length;

    bf_result_t pending_results [$];
    int         errors = 0;
    int         cycle_count = 0;
    int         long_hold = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    brainfuck_interpreter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .address      (address),
        .program_byte (program_byte),
        .input_byte   (input_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .run_state    (run_state),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .input_used   (input_used),
        .next_pc      (next_pc)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic void bf_restart();
        foreach (bf_tape[i])
            bf_tape[i] = 8'h00;
        bf_pc   = '0;
        bf_cell = '0;
        bf_halt = RUN_ACTIVE;
    endfunction

    function automatic logic [PC_W-1:0] bf_limit();
        return (bf_length < BFI_PROG_DEPTH) ? bf_length : PC_W'(BFI_PROG_DEPTH);
    endfunction

    function automatic void bf_execute(input logic [7:0] in_byte, inout bf_result_t r);
        logic [PC_W-1:0] lim;
        logic [7:0]      op;
        int              a;
        int              depth;
        bit              found;
        lim   = bf_limit();
        found = 1'b1;
        if (bf_pc >= lim)
        begin
            bf_halt = RUN_END;
            return;
        end
        op = bf_prog[bf_pc[11:0]];
        case (op)
            CH_GT:    bf_cell = bf_cell + 15'd1;
            CH_LT:    bf_cell = bf_cell - 15'd1;
            CH_PLUS:  bf_tape[bf_cell] = bf_tape[bf_cell] + 8'd1;
            CH_MINUS: bf_tape[bf_cell] = bf_tape[bf_cell] - 8'd1;
            CH_DOT:
            begin
                r.out_valid = 1'b1;
                r.out_byte  = bf_tape[bf_cell];
            end
            CH_COMMA:
            begin
                bf_tape[bf_cell] = in_byte;
                r.input_used     = 1'b1;
            end
            CH_OPEN:
                if (bf_tape[bf_cell] == 8'h00)
                begin
                    found = 1'b0;
                    depth = 1;
                    for (a = int'(bf_pc) + 1; a < int'(lim) && !found; a++)
                    begin
                        if (bf_prog[12'(a)] == CH_OPEN)
                            depth++;
                        else if (bf_prog[12'(a)] == CH_CLOSE)
                        begin
                            depth--;
                            if (depth == 0)
                            begin
                                found = 1'b1;
                                bf_pc = PC_W'(a);
                            end
                        end
                    end
                end
            CH_CLOSE:
                if (bf_tape[bf_cell] != 8'h00)
                begin
                    found = 1'b0;
                    depth = 1;
                    a     = int'(bf_pc);
                    while (a > 0 && !found)
                    begin
                        a--;
                        if (bf_prog[12'(a)] == CH_CLOSE)
                            depth++;
                        else if (bf_prog[12'(a)] == CH_OPEN)
                        begin
                            depth--;
                            if (depth == 0)
                            begin
                                found = 1'b1;
                                bf_pc = PC_W'(a);
                            end
                        end
                    end
                end
            default: ;
        endcase
        if (!found)
        begin
            bf_halt = RUN_ERROR;
            return;
        end
        bf_pc = bf_pc + 1'b1;
        if (bf_pc >= lim)
            bf_halt = RUN_END;
    endfunction

    function automatic bf_result_t bf_step(input logic [1:0] cmd, input logic [11:0] addr,
                                           input logic [7:0] pbyte, input logic [7:0] ibyte);
        bf_result_t r;
        r = '0;
        case (cmd)
            CMD_LOAD:    bf_prog[addr] = pbyte;
            CMD_EXEC:    if (bf_halt == RUN_ACTIVE) bf_execute(ibyte, r);
            CMD_RESTART: bf_restart();
            default: ;
        endcase
        r.run_state = bf_halt;
        r.next_pc   = bf_pc;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [PC_W-1:0] want,
                                        input logic [PC_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s expected %0d actual %0d", name, want, got);
        end
    endfunction

    function automatic void check_result();
        bf_result_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            $error("result transfer with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        check_field("run_state", PC_W'(want.run_state), PC_W'(run_state));
        check_field("out_valid", PC_W'(want.out_valid), PC_W'(out_valid));
        check_field("out_byte", PC_W'(want.out_byte), PC_W'(out_byte));
        check_field("input_used", PC_W'(want.input_used), PC_W'(input_used));
        check_field("next_pc", want.next_pc, next_pc);
    endfunction

    // result side: checks each transfer and drives stall
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_result();
        if (long_hold > 0)
        begin
            res_stall <= 1'b1;
            long_hold--;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            res_stall  <= 1'b1;
            stall_left = $urandom_range(0, 16);
        end
        else
            res_stall <= 1'b0;
    end

    task automatic send_item(input logic [1:0] cmd, input logic [11:0] addr,
                             input logic [7:0] pbyte, input logic [7:0] ibyte);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        command      <= cmd;
        address      <= addr;
        program_byte <= pbyte;
        input_byte   <= ibyte;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_results.push_back(bf_step(cmd, addr, pbyte, ibyte));
    endtask

    task automatic send_exec(input logic [7:0] ibyte);
        send_item(CMD_EXEC, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), ibyte);
    endtask

    task automatic send_restart();
        send_item(CMD_RESTART, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= PC_W'(value);
        @(posedge clk);
        bf_length = PC_W'(value);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_OPEN || b == CH_CLOSE)
            b = b ^ 8'h01;
        return b;
    endfunction

    // low part of the program store is filled first, lengths never reach past it
    task automatic test_fill_memory();
        logic [7:0] b;
        for (int a = 0; a < FILL_TOP; a++)
        begin
            b = plain_byte();
            if (a == 0)
                b = CH_OPEN;
            else if (a == FILL_TOP - 1)
                b = CH_CLOSE;
            send_item(CMD_LOAD, 12'(a), b, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_empty_program();
        send_exec(8'h00);
        send_exec(8'hFF);
        send_item(CMD_UNUSED, 12'hFFF, 8'hFF, 8'hFF);
        send_item(CMD_UNUSED, 12'h000, 8'h00, 8'h00);
    endtask

    task automatic test_full_scan();
        wait_idle();
        write_length(FILL_TOP);
        send_restart();
        send_exec(8'h00);
        send_exec(8'h00);
        wait_idle();
        send_restart();
        send_item(CMD_LOAD, 12'(FILL_TOP - 1), plain_byte(), 8'h00);
        send_exec(8'h00);
        send_exec(8'h00);
    endtask

    task automatic test_instruction_set();
        logic [7:0] code [22];
        code = '{CH_LT, CH_MINUS, CH_DOT, CH_GT, CH_COMMA, CH_PLUS, CH_DOT, CH_OPEN,
                 CH_OPEN, CH_PLUS, CH_CLOSE, CH_CLOSE, CH_PLUS, CH_PLUS, CH_OPEN, CH_MINUS,
                 CH_CLOSE, CH_COMMA, 8'h00, 8'hFF, CH_PLUS, CH_CLOSE};
        foreach (code[a])
            send_item(CMD_LOAD, 12'(a), code[a], 8'($urandom_range(0, 255)));
        wait_idle();
        write_length(22);
        send_restart();
        for (int k = 0; k < 40 && bf_halt == RUN_ACTIVE; k++)
            send_exec((bf_pc < 10) ? 8'hFF : 8'h00);
        send_exec(8'hFF);
    endtask

    // pc beyond a shortened program halts without executing
    task automatic test_end_of_program();
        wait_idle();
        write_length(22);
        send_restart();
        repeat (3) send_exec(8'h55);
        wait_idle();
        write_length(2);
        send_exec(8'hAA);
        send_exec(8'hAA);
    endtask

    task automatic test_backpressure();
        wait_idle();
        long_hold = 300;
        for (int k = 0; k < 30; k++)
            case (k % 3)
                0:       send_exec(8'($urandom_range(0, 255)));
                1:       send_item(CMD_UNUSED, 12'($urandom_range(0, 4095)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: send_item(CMD_LOAD, 12'hFFF, plain_byte(), 8'($urandom_range(0, 255)));
            endcase
    endtask

    task automatic load_program(input int n, inout int sent);
        int         depth;
        int         roll;
        logic [7:0] b;
        depth = 0;
        for (int a = 0; a < n; a++)
        begin
            roll = $urandom_range(0, 99);
            if (n - a <= depth)
            begin
                b = CH_CLOSE;
                depth--;
            end
            else if (roll < 12 && n - a > depth + 1)
            begin
                b = CH_OPEN;
                depth++;
            end
            else if (roll < 24 && depth > 0)
            begin
                b = CH_CLOSE;
                depth--;
            end
            else if (roll < 26)
                b = roll[0] ? CH_OPEN : CH_CLOSE;
            else
                case ($urandom_range(0, 9))
                    0, 1:    b = CH_PLUS;
                    2:       b = CH_MINUS;
                    3:       b = CH_GT;
                    4:       b = CH_LT;
                    5, 6:    b = CH_DOT;
                    7:       b = CH_COMMA;
                    default: b = plain_byte();
                endcase
            send_item(CMD_LOAD, 12'(a), b, 8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    task automatic test_random_programs();
        int sent;
        int n;
        int roll;
        int budget;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > RANDOM_ITEMS - 200)
                quiet = 1'b1;
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            roll = $urandom_range(0, 9);
            wait_idle();
            if (roll < 7)
                write_length(n);
            else if (roll < 8)
                write_length($urandom_range(0, n));
            else
                write_length($urandom_range(0, FILL_TOP));
            send_restart();
            sent++;
            load_program(n, sent);
            budget = $urandom_range(20, 110);
            while (budget > 0)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send_item(CMD_UNUSED, 12'($urandom_range(0, 4095)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (roll == 1)
                    send_item(CMD_LOAD, 12'($urandom_range(0, n - 1)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    send_exec(8'($urandom_range(0, 255)));
                sent++;
                budget--;
                if (bf_halt != RUN_ACTIVE && budget > 3)
                    budget = $urandom_range(1, 3);
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        cmd_valid    <= 1'b0;
        command      <= CMD_LOAD;
        address      <= '0;
        program_byte <= '0;
        input_byte   <= '0;
        res_stall    <= 1'b0;
        bf_restart();
        bf_length = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_memory();
        test_empty_program();
        test_full_scan();
        test_instruction_set();
        test_end_of_program();
        test_backpressure();
        test_random_programs();
        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
